// File: src/bpa_pkg.sv
// bpa_pkg: shared constants, codes and types of the buddy page allocator.
// No dependencies; imported by bpa_front, bpa_engine and the top level.
package bpa_pkg;

	localparam int PAGE_COUNT  = 4096;
	localparam int ORDER_COUNT = 11;
	localparam int PAGE_W      = $clog2(PAGE_COUNT);
	localparam int LINK_W      = PAGE_W + 1;
	localparam int ORD_W       = 4;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(PAGE_COUNT);

	// configuration register indexes (word address)
	localparam logic REG_MANAGED_PAGES = 1'b0;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_ADD     = 2'd2,
		MODE_RESERVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NO_MEMORY = 2'd1,
		STS_INVALID   = 2'd2,
		STS_ORDER     = 2'd3
	} status_t;

	// one classified request in the queue between front and engine
	typedef struct packed {
		mode_t              mode;
		logic [ORD_W-1:0]   order;
		logic [PAGE_W-1:0]  page;
		logic [LINK_W-1:0]  end_page;
		logic               rejected;
		status_t            pre_status;
	} q_entry_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_SCAN,
		ST_A_SPLIT,
		ST_A_FIN,
		ST_F_RD,
		ST_F_CHK,
		ST_M_RD,
		ST_M_CHK,
		ST_D_LOOP,
		ST_D_CHK,
		ST_R_LOOP,
		ST_U_RD,
		ST_U_WR,
		ST_P1,
		ST_P2,
		ST_DONE
	} state_t;

	function automatic logic [LINK_W-1:0] limit_of(input logic [LINK_W-1:0] managed);
		return (managed > NIL) ? NIL : managed;
	endfunction

endpackage

// File: src/bpa_ram.sv
// bpa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/bpa_front.sv
// bpa_front: accepts requests, checks order and limit, clips ranges and
// queues the classified transaction for the engine. Depends on bpa_pkg.
module bpa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [3:0]                  block_order,
	input  logic [11:0]                 page_number,
	input  logic [12:0]                 end_page_number,
	input  logic [bpa_pkg::LINK_W-1:0]  managed,
	input  logic                        clearing,
	output logic                        q_valid,
	output bpa_pkg::q_entry_t           q_entry,
	input  logic                        q_pop
);
	import bpa_pkg::*;

	q_entry_t          fifo_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        cnt_q;
	logic [LINK_W-1:0] lim;
	logic [LINK_W-1:0] pfn;
	logic [LINK_W-1:0] bsize;
	q_entry_t          ent;
	logic              push;

	assign lim   = limit_of(managed);
	assign pfn   = LINK_W'(page_number);
	assign bsize = LINK_W'(1) << block_order;

	// classify the request
	always_comb begin
		ent            = '0;
		ent.mode       = mode_t'(mode);
		ent.order      = block_order;
		ent.page       = page_number;
		ent.end_page   = (end_page_number > lim) ? lim : end_page_number;
		ent.rejected   = 1'b0;
		ent.pre_status = STS_OK;
		if ((mode_t'(mode) == MODE_ALLOC || mode_t'(mode) == MODE_FREE)
			&& block_order >= ORD_W'(ORDER_COUNT)) begin
			ent.rejected   = 1'b1;
			ent.pre_status = STS_ORDER;
		end else if (mode_t'(mode) == MODE_FREE && (pfn >= lim || bsize > lim - pfn)) begin
			ent.rejected   = 1'b1;
			ent.pre_status = STS_INVALID;
		end
	end

	assign in_ready = (cnt_q != 2'd2) && !clearing;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_entry  = fifo_q[rd_ptr_q];

	// two-entry queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

endmodule

// File: src/bpa_engine.sv
// bpa_engine: sequencer that runs allocate, free/merge, add and reserve on the
// free lists and per-page RAMs, and holds the result register.
// Depends on bpa_pkg and bpa_ram.
module bpa_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bpa_pkg::LINK_W-1:0]  managed,
	input  logic                        q_valid,
	input  bpa_pkg::q_entry_t           q_entry,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [11:0]                 granted_page,
	output logic [12:0]                 free_count
);
	import bpa_pkg::*;

	state_t            state_q, state_d, ret_q;
	logic [PAGE_W-1:0] clr_q;
	logic [ORD_W-1:0]  ord_q, tgt_q, lo_q;
	logic [LINK_W-1:0] pg_q, end_q, node_q, lnk_q;
	logic              tail_q;
	logic [LINK_W-1:0] count_q;
	status_t           st_q;
	logic [PAGE_W-1:0] granted_q;
	logic [LINK_W-1:0] head_q [ORDER_COUNT];
	logic [LINK_W-1:0] tail_lq [ORDER_COUNT];

	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [PAGE_W-1:0] out_granted_q;
	logic [LINK_W-1:0] out_free_q;

	// RAM ports
	logic              nx_we, pv_we, od_we, fh_we, rv_we;
	logic [PAGE_W-1:0] nx_wa, pv_wa, od_wa, fh_wa, rv_wa;
	logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
	logic [ORD_W-1:0]  od_wd, od_rd;
	logic              fh_wd, rv_wd, fh_rd, rv_rd;
	logic [PAGE_W-1:0] link_ra, mark_ra;

	// shared datapath terms
	logic [LINK_W-1:0] lim;
	logic [ORD_W-1:0]  lidx;
	logic [LINK_W-1:0] lh, lt;
	logic [ORD_W-1:0]  split_o;
	logic [LINK_W-1:0] split_b, mrg_b, rem;
	logic [ORD_W-1:0]  add_o;
	logic              merge_go, merge_ok, emit;
	logic [LINK_W:0]   sum_ord;

	assign lim     = limit_of(managed);
	assign lidx    = (state_q == ST_A_SCAN) ? ((ord_q < ORD_W'(ORDER_COUNT)) ? ord_q : '0)
	                                        : lo_q;
	assign lh      = head_q[lidx];
	assign lt      = tail_lq[lidx];
	assign split_o = ord_q - ORD_W'(1);
	assign split_b = pg_q + (LINK_W'(1) << split_o);
	assign mrg_b   = pg_q ^ (LINK_W'(1) << ord_q);
	assign rem     = end_q - pg_q;
	assign merge_go = (ord_q < ORD_W'(ORDER_COUNT - 1)) && (mrg_b < lim);
	assign merge_ok = fh_rd && (od_rd == ord_q) && !rv_rd;
	assign emit    = !out_valid_q || out_ready;
	assign sum_ord = {1'b0, count_q} + (LINK_W'(1) << ord_q);

	// largest aligned block that fits the rest of the range
	always_comb begin
		add_o = '0;
		for (int o = 1; o < ORDER_COUNT; o++) begin
			if ((pg_q & ((LINK_W'(1) << o) - LINK_W'(1))) == '0
				&& (LINK_W'(1) << o) <= rem) begin
				add_o = ORD_W'(o);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:   if (clr_q == PAGE_W'(PAGE_COUNT - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					if (q_entry.rejected) begin
						state_d = ST_DONE;
					end else begin
						case (q_entry.mode)
							MODE_ALLOC: state_d = ST_A_SCAN;
							MODE_FREE:  state_d = ST_F_RD;
							MODE_ADD:   state_d = ST_D_LOOP;
							default:    state_d = ST_R_LOOP;
						endcase
					end
				end
			end
			ST_A_SCAN: begin
				if (ord_q >= ORD_W'(ORDER_COUNT)) state_d = ST_DONE;
				else if (lh < NIL)               state_d = ST_U_RD;
			end
			ST_A_SPLIT: begin
				if (ord_q > tgt_q) begin
					if (split_b < NIL) state_d = ST_P1;
				end else begin
					state_d = ST_A_FIN;
				end
			end
			ST_A_FIN:   state_d = ST_DONE;
			ST_F_RD:    state_d = ST_F_CHK;
			ST_F_CHK:   state_d = fh_rd ? ST_DONE : ST_M_RD;
			ST_M_RD:    state_d = merge_go ? ST_M_CHK : ST_P1;
			ST_M_CHK:   state_d = merge_ok ? ST_U_RD : ST_P1;
			ST_D_LOOP:  state_d = (pg_q < end_q) ? ST_D_CHK : ST_DONE;
			ST_D_CHK:   state_d = fh_rd ? ST_D_LOOP : ST_P1;
			ST_R_LOOP:  if (pg_q >= end_q) state_d = ST_DONE;
			ST_U_RD:    state_d = ST_U_WR;
			ST_U_WR:    state_d = ret_q;
			ST_P1:      state_d = ((tail_q ? lt : lh) < NIL) ? ST_P2 : ret_q;
			ST_P2:      state_d = ret_q;
			ST_DONE:    if (emit) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		nx_we = 1'b0; nx_wa = node_q[PAGE_W-1:0]; nx_wd = NIL;
		pv_we = 1'b0; pv_wa = node_q[PAGE_W-1:0]; pv_wd = NIL;
		od_we = 1'b0; od_wa = node_q[PAGE_W-1:0]; od_wd = lo_q;
		fh_we = 1'b0; fh_wa = node_q[PAGE_W-1:0]; fh_wd = 1'b0;
		rv_we = 1'b0; rv_wa = pg_q[PAGE_W-1:0];   rv_wd = 1'b0;
		link_ra = node_q[PAGE_W-1:0];
		mark_ra = pg_q[PAGE_W-1:0];
		case (state_q)
			ST_CLEAR: begin
				fh_we = 1'b1; fh_wa = clr_q;
				rv_we = 1'b1; rv_wa = clr_q;
			end
			ST_A_SCAN: begin
				if (ord_q < ORD_W'(ORDER_COUNT) && lh < NIL) begin
					fh_we = 1'b1; fh_wa = lh[PAGE_W-1:0];
				end
			end
			ST_A_SPLIT: begin
				if (ord_q > tgt_q && split_b < NIL) begin
					rv_we = 1'b1; rv_wa = split_b[PAGE_W-1:0];
				end
			end
			ST_A_FIN: begin
				od_we = 1'b1; od_wa = pg_q[PAGE_W-1:0]; od_wd = tgt_q;
			end
			ST_M_RD:    mark_ra = mrg_b[PAGE_W-1:0];
			ST_M_CHK: begin
				if (merge_ok) begin
					fh_we = 1'b1; fh_wa = mrg_b[PAGE_W-1:0];
				end
			end
			ST_R_LOOP: begin
				if (pg_q < end_q) begin
					rv_we = 1'b1; rv_wd = 1'b1;
				end
			end
			ST_U_WR: begin
				if (pv_rd < NIL) begin
					nx_we = 1'b1; nx_wa = pv_rd[PAGE_W-1:0]; nx_wd = nx_rd;
				end
				if (nx_rd < NIL) begin
					pv_we = 1'b1; pv_wa = nx_rd[PAGE_W-1:0]; pv_wd = pv_rd;
				end
			end
			ST_P1: begin
				nx_we = 1'b1; nx_wd = tail_q ? NIL : lh;
				pv_we = 1'b1; pv_wd = tail_q ? lt : NIL;
				od_we = 1'b1;
				fh_we = 1'b1; fh_wd = 1'b1;
			end
			ST_P2: begin
				if (tail_q) begin
					nx_we = 1'b1; nx_wa = lnk_q[PAGE_W-1:0]; nx_wd = node_q;
				end else begin
					pv_we = 1'b1; pv_wa = lnk_q[PAGE_W-1:0]; pv_wd = node_q;
				end
			end
			default: ;
		endcase
	end

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign clearing = (state_q == ST_CLEAR);

	// state, list heads and tails, free count, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_q[i]  <= NIL;
				tail_lq[i] <= NIL;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + PAGE_W'(1);
			end
			// result valid: set on completion, cleared when taken
			if (state_q == ST_DONE && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_F_CHK: begin
					if (!fh_rd) begin
						count_q <= (sum_ord > (LINK_W+1)'(PAGE_COUNT)) ? NIL : sum_ord[LINK_W-1:0];
					end
				end
				ST_D_CHK: begin
					if (!fh_rd) begin
						count_q <= (sum_ord > (LINK_W+1)'(PAGE_COUNT)) ? NIL : sum_ord[LINK_W-1:0];
					end
				end
				ST_A_FIN: begin
					count_q <= (count_q > (LINK_W'(1) << tgt_q))
						? count_q - (LINK_W'(1) << tgt_q) : '0;
				end
				ST_U_WR: begin
					if (pv_rd >= NIL) head_q[lo_q] <= nx_rd;
					if (nx_rd >= NIL) tail_lq[lo_q] <= pv_rd;
				end
				ST_P1: begin
					if (tail_q) begin
						tail_lq[lo_q] <= node_q;
						if (lt >= NIL) head_q[lo_q] <= node_q;
					end else begin
						head_q[lo_q] <= node_q;
						if (lh >= NIL) tail_lq[lo_q] <= node_q;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ord_q     <= q_entry.order;
				tgt_q     <= q_entry.order;
				pg_q      <= LINK_W'(q_entry.page);
				end_q     <= q_entry.end_page;
				st_q      <= q_entry.pre_status;
				granted_q <= '0;
			end
			ST_A_SCAN: begin
				if (ord_q >= ORD_W'(ORDER_COUNT)) begin
					st_q <= STS_NO_MEMORY;
				end else if (lh < NIL) begin
					pg_q   <= lh;
					node_q <= lh;
					lo_q   <= ord_q;
					ret_q  <= ST_A_SPLIT;
				end else begin
					ord_q <= ord_q + ORD_W'(1);
				end
			end
			ST_A_SPLIT: begin
				if (ord_q > tgt_q) begin
					ord_q  <= split_o;
					node_q <= split_b;
					lo_q   <= split_o;
					tail_q <= 1'b0;
					ret_q  <= ST_A_SPLIT;
				end
			end
			ST_A_FIN:   granted_q <= pg_q[PAGE_W-1:0];
			ST_F_CHK:   if (fh_rd) st_q <= STS_INVALID;
			ST_M_RD: begin
				if (!merge_go) begin
					node_q <= pg_q;
					lo_q   <= ord_q;
					tail_q <= 1'b0;
					ret_q  <= ST_DONE;
				end
			end
			ST_M_CHK: begin
				if (merge_ok) begin
					node_q <= mrg_b;
					lo_q   <= ord_q;
					pg_q   <= (mrg_b < pg_q) ? mrg_b : pg_q;
					ord_q  <= ord_q + ORD_W'(1);
					ret_q  <= ST_M_RD;
				end else begin
					node_q <= pg_q;
					lo_q   <= ord_q;
					tail_q <= 1'b0;
					ret_q  <= ST_DONE;
				end
			end
			ST_D_LOOP:  ord_q <= add_o;
			ST_D_CHK: begin
				node_q <= pg_q;
				lo_q   <= ord_q;
				tail_q <= 1'b1;
				ret_q  <= ST_D_LOOP;
				pg_q   <= pg_q + (LINK_W'(1) << ord_q);
			end
			ST_R_LOOP:  if (pg_q < end_q) pg_q <= pg_q + LINK_W'(1);
			ST_P1:      lnk_q <= tail_q ? lt : lh;
			default: ;
		endcase
		if (state_q == ST_DONE && emit) begin
			out_status_q  <= st_q;
			out_granted_q <= granted_q;
			out_free_q    <= count_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign granted_page = out_granted_q;
	assign free_count   = out_free_q;

	// per-page stores
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(link_ra), .rdata(nx_rd)
	);
	bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(link_ra), .rdata(pv_rd)
	);
	bpa_ram #(.WIDTH(ORD_W), .DEPTH(PAGE_COUNT)) u_order (
		.clk(clk), .we(od_we), .waddr(od_wa), .wdata(od_wd), .raddr(mark_ra), .rdata(od_rd)
	);
	bpa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_fhead (
		.clk(clk), .we(fh_we), .waddr(fh_wa), .wdata(fh_wd), .raddr(mark_ra), .rdata(fh_rd)
	);
	bpa_ram #(.WIDTH(1), .DEPTH(PAGE_COUNT)) u_resv (
		.clk(clk), .we(rv_we), .waddr(rv_wa), .wdata(rv_wd), .raddr(mark_ra), .rdata(rv_rd)
	);

	// free count never exceeds the page count
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL) else $error("free count out of range");

	// list operations always target a real order
	a_list_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P1 || state_q == ST_U_WR) |-> lo_q < ORD_W'(ORDER_COUNT))
		else $error("list order out of range");

	// clearing pass ends only after the last page
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == ST_CLEAR && state_q != ST_CLEAR)
		|-> $past(clr_q) == PAGE_W'(PAGE_COUNT - 1)) else $error("early clear exit");

	// a queue pop always moves the engine out of idle into a transaction
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE && state_q != ST_CLEAR) else $error("pop not dispatched");

endmodule

// File: src/buddy_page_allocator_top.sv
// buddy_page_allocator_top: top level with the configuration register, the
// request front end and the allocation engine. Depends on bpa_pkg, bpa_front, bpa_engine.
//
//  channel   handshake             payload
//  request   in_valid / in_ready   mode, block_order, page_number, end_page_number
//  result    out_valid / out_ready status, granted_page, free_count
//  config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// A transaction is dispatched from the queue and ends in the result register.
// Allocate scans orders upward, unlinks the block found, splits off one half per
// order down to the target and finishes; free checks the page, merges while its
// buddy is a free block of the same order and pushes the merged block; add links
// the largest aligned blocks that fit the range; reserve marks each page of it.
// After reset a clearing pass over all 4096 pages runs with in_ready low. Up to two
// requests queue ahead of the engine; a held result stalls only the engine.
module buddy_page_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  block_order,
	input  logic [11:0] page_number,
	input  logic [12:0] end_page_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [11:0] granted_page,
	output logic [12:0] free_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bpa_pkg::*;

	logic [LINK_W-1:0] managed_q;
	logic              q_valid, q_pop, clearing;
	q_entry_t          q_entry;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= NIL;
		end else if (psel && penable && pwrite && paddr[2] == REG_MANAGED_PAGES) begin
			managed_q <= pwdata[LINK_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MANAGED_PAGES) ? 32'(managed_q) : '0;

	bpa_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .block_order(block_order),
		.page_number(page_number), .end_page_number(end_page_number),
		.managed(managed_q), .clearing(clearing),
		.q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
	);

	bpa_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.managed(managed_q),
		.q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
		.clearing(clearing),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .granted_page(granted_page), .free_count(free_count)
	);

endmodule
